/* rtl/sector_visibility_filter_defines.svh */
// Assertion macros for the sector visibility filter.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef SECTOR_VISIBILITY_FILTER_DEFINES_SVH
`define SECTOR_VISIBILITY_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising clock edge out of reset
`define SVF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svf: implication check failed");

// next-cycle implication
`define SVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svf: next-cycle check failed");

`else

`define SVF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SVF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/svf_pkg.sv */
// Shared types and constants of the sector visibility filter.
// Used by svf_cordic and sector_visibility_filter; depends on nothing.
`timescale 1ns / 1ps

package svf_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_POSE_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSE_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 3'd4;

  // register widths
  localparam int unsigned POSE_W  = 32;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned RANGE_W = 32;
  localparam int unsigned VIEW_W  = 17;
  localparam int unsigned TAG_W   = 32;

  localparam logic [RANGE_W-1:0] RANGE_RST = 32'd65536;
  localparam logic [VIEW_W-1:0]  VIEW_RST  = 17'd65536;

  // CORDIC angle accumulator: 2^32 is one full turn
  localparam int unsigned ACC_W = 32;
  localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam int unsigned ATAN_N = 24;
  // round(atan(2^-i) * 2^32 / 2pi)
  localparam logic [ACC_W-1:0] ATAN_TURN [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // sideband that travels with a word through the CORDIC stages
  typedef struct packed {
    logic vld;   // slot holds a word
    logic zero;  // cell sits on the robot, bearing forced to 0
  } svf_side_t;

endpackage

/* rtl/svf_square.sv */
// Two-stage unsigned squarer built from half-width partial products.
// No package dependency; instantiated by svf_range.
`timescale 1ns / 1ps

module svf_square #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   a_i,
  output logic [2*W-1:0] sq_o
);

  localparam int unsigned LO = (W + 1) / 2;
  localparam int unsigned HI = W - LO;
  localparam int unsigned SW = 2 * W;

  logic [LO-1:0]      lo;
  logic [HI-1:0]      hi;
  logic [2*HI-1:0]    hh_q;
  logic [HI+LO-1:0]   hl_q;
  logic [2*LO-1:0]    ll_q;
  logic [SW-1:0]      sq_q;

  assign lo = a_i[LO-1:0];
  assign hi = a_i[W-1:LO];

  // a^2 = hh*2^(2LO) + 2*hl*2^LO + ll
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= hi * hi;
      hl_q <= hi * lo;
      ll_q <= lo * lo;
      sq_q <= (SW'(hh_q) << (2 * LO)) + (SW'(hl_q) << (LO + 1)) + SW'(ll_q);
    end
  end

  assign sq_o = sq_q;

endmodule

/* rtl/svf_range.sv */
// Exact range test: dx^2 + dy^2 <= r^2, delayed to a fixed latency.
// Uses svf_square; no package dependency.
`timescale 1ns / 1ps

module svf_range #(
  parameter int unsigned CW  = 32,
  parameter int unsigned LAT = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] mag_x_i,
  input  logic [CW-1:0] mag_y_i,
  input  logic [CW-1:0] rad_i,
  output logic          ok_o
);

  localparam int unsigned DLY = LAT - 4;

  logic [2*CW-1:0] sq_x, sq_y, sq_r;
  logic [2*CW:0]   sum_q;
  logic            cmp_q;
  logic            dly_q [DLY];

  svf_square #(.W(CW)) u_sq_x (.clk_i(clk_i), .en_i(en_i), .a_i(mag_x_i), .sq_o(sq_x));
  svf_square #(.W(CW)) u_sq_y (.clk_i(clk_i), .en_i(en_i), .a_i(mag_y_i), .sq_o(sq_y));
  // the user must keep the radius register static while words are in flight; the block does not enforce it
  svf_square #(.W(CW)) u_sq_r (.clk_i(clk_i), .en_i(en_i), .a_i(rad_i), .sq_o(sq_r));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= {1'b0, sq_x} + {1'b0, sq_y};
      cmp_q    <= (sum_q <= {1'b0, sq_r});
      dly_q[0] <= cmp_q;
      for (int k = 1; k < DLY; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign ok_o = dly_q[DLY-1];

endmodule

/* rtl/svf_cordic.sv */
// Vectoring CORDIC, one micro-rotation per register stage, angle in turns.
// Uses svf_pkg (arctangent table, sideband type).
`timescale 1ns / 1ps

module svf_cordic #(
  parameter int unsigned XW     = 35,
  parameter int unsigned STAGES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  svf_pkg::svf_side_t           side_i,
  input  logic signed [XW-1:0]         x_i,
  input  logic signed [XW-1:0]         y_i,
  input  logic [svf_pkg::ACC_W-1:0]    acc_i,
  output svf_pkg::svf_side_t           side_o,
  output logic [svf_pkg::ACC_W-1:0]    acc_o
);

  logic signed [XW-1:0]          x_q   [STAGES-2];
  logic signed [XW-1:0]          y_q   [STAGES-1];
  logic signed [XW-1:0]          x_nx  [STAGES-2];
  logic signed [XW-1:0]          y_nx  [STAGES-1];
  logic [svf_pkg::ACC_W-1:0]     acc_q [STAGES];
  logic [svf_pkg::ACC_W-1:0]     acc_nx[STAGES];
  svf_pkg::svf_side_t            side_q[STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0]      y_cur;
    logic [svf_pkg::ACC_W-1:0] acc_cur;
    logic                      cw;  // y >= 0: rotate clockwise

    if (i == 0) begin : g_first
      assign y_cur   = y_i;
      assign acc_cur = acc_i;
    end else begin : g_next
      assign y_cur   = y_q[i-1];
      assign acc_cur = acc_q[i-1];
    end

    assign cw = ~y_cur[XW-1];
    assign acc_nx[i] = cw ? acc_cur + svf_pkg::ATAN_TURN[i]
                          : acc_cur - svf_pkg::ATAN_TURN[i];

    // last stage only needs the angle, the one before it only y
    if (i < STAGES - 1) begin : g_rot
      logic signed [XW-1:0] x_cur;
      if (i == 0) begin : g_x0
        assign x_cur = x_i;
      end else begin : g_xn
        assign x_cur = x_q[i-1];
      end
      assign y_nx[i] = cw ? y_cur - (x_cur >>> i) : y_cur + (x_cur >>> i);
      if (i < STAGES - 2) begin : g_xrot
        assign x_nx[i] = cw ? x_cur + (y_cur >>> i) : x_cur - (y_cur >>> i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) begin
        side_q[k] <= '0;
      end
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STAGES; k++) begin
        acc_q[k] <= acc_nx[k];
      end
      for (int k = 0; k < STAGES - 1; k++) begin
        y_q[k] <= y_nx[k];
      end
      for (int k = 0; k < STAGES - 2; k++) begin
        x_q[k] <= x_nx[k];
      end
    end
  end

  assign side_o = side_q[STAGES-1];
  assign acc_o  = acc_q[STAGES-1];

endmodule

/* rtl/sector_visibility_filter.sv */
// Top level of the sector visibility filter: config registers, pipeline, output buffer.
// Uses svf_pkg, svf_range, svf_cordic and sector_visibility_filter_defines.svh.
`timescale 1ns / 1ps

`include "sector_visibility_filter_defines.svh"

//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+------------------------------
//  cell    | in        | cell_valid_i / cell_stall_o  | cell_x_i, cell_y_i, cell_tag_i
//  seen    | out       | seen_valid_o / seen_stall_i  | seen_x_o, seen_y_o, seen_tag_o
//  cfg     | in        | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// One cell word is taken every cycle while cell_stall_o is low. The depth of a kept cell's
// path is set by the CORDIC, one micro-rotation per stage.
// Dropped cells leave an empty slot and produce no output word.
// Reset clears all valid bits and loads the register reset values.
// The whole pipeline advances while the skid register is empty; cell_stall_o is that
// registered flag, so a stall on the output side reaches the input in the following cycle.
module sector_visibility_filter #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [svf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [svf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // cell words in
  input  logic                               cell_valid_i,
  output logic                               cell_stall_o,
  input  logic signed [COORD_WIDTH-1:0]      cell_x_i,
  input  logic signed [COORD_WIDTH-1:0]      cell_y_i,
  input  logic [svf_pkg::TAG_W-1:0]          cell_tag_i,
  // visible cells out
  output logic                               seen_valid_o,
  input  logic                               seen_stall_i,
  output logic signed [COORD_WIDTH-1:0]      seen_x_o,
  output logic signed [COORD_WIDTH-1:0]      seen_y_o,
  output logic [svf_pkg::TAG_W-1:0]          seen_tag_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;          // exact difference
  localparam int unsigned XW = CW + 3;          // CORDIC datapath, covers gain
  localparam int unsigned A  = ANGLE_BITS;
  localparam int unsigned VW = (A + 2 > svf_pkg::VIEW_W) ? A + 2 : svf_pkg::VIEW_W;
  localparam int unsigned PD = CORDIC_STAGES + 5;  // payload stages up to the last
  localparam int unsigned AW = svf_pkg::ACC_W;
  localparam logic [AW-1:0] RND = AW'(1) << (AW - 1 - A);

  // ---------------------------------------------------------------- registers
  logic [svf_pkg::POSE_W-1:0]  pose_x_q, pose_y_q;
  logic [svf_pkg::HEAD_W-1:0]  heading_q;
  logic [svf_pkg::RANGE_W-1:0] range_q;
  logic [svf_pkg::VIEW_W-1:0]  view_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
      range_q   <= svf_pkg::RANGE_RST;
      view_q    <= svf_pkg::VIEW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svf_pkg::CFG_POSE_X:      pose_x_q  <= cfg_data_i;
        svf_pkg::CFG_POSE_Y:      pose_y_q  <= cfg_data_i;
        svf_pkg::CFG_HEADING:     heading_q <= cfg_data_i[svf_pkg::HEAD_W-1:0];
        svf_pkg::CFG_RANGE_LIMIT: range_q   <= cfg_data_i;
        svf_pkg::CFG_VIEW_WIDTH:  view_q    <= cfg_data_i[svf_pkg::VIEW_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // pose is taken as a CW-bit two's complement value (zero-padded if CW > 32)
  logic signed [CW-1:0] pose_x_c, pose_y_c;
  logic [CW-1:0]        rad_c;
  logic [A-1:0]         heading_c;

  assign pose_x_c  = CW'(pose_x_q);
  assign pose_y_c  = CW'(pose_y_q);
  assign rad_c     = CW'(range_q);
  assign heading_c = A'(heading_q);

  // ---------------------------------------------------------------- control
  logic en;           // pipeline advance
  logic skid_vld_q;
  logic out_vld_q;
  logic out_free;

  assign en           = ~skid_vld_q;
  assign cell_stall_o = skid_vld_q;
  assign out_free     = ~out_vld_q | ~seen_stall_i;

  // ---------------------------------------------------------------- S0: offsets
  logic               vld0_q;
  logic signed [DW-1:0] dx0_q, dy0_q;

  // ---------------------------------------------------------------- S1: fold
  logic               vld1_q, zero1_q;
  logic [CW-1:0]      mx1_q, my1_q;
  logic signed [XW-1:0] cx1_q, cy1_q;
  logic [AW-1:0]      ca1_q;
  logic               neg0;
  logic signed [DW-1:0] ndx0, ndy0;

  assign neg0 = dx0_q[DW-1];
  assign ndx0 = -dx0_q;
  assign ndy0 = -dy0_q;

  // payload line, one entry per stage
  logic signed [CW-1:0]       pay_x_q   [PD];
  logic signed [CW-1:0]       pay_y_q   [PD];
  logic [svf_pkg::TAG_W-1:0]  pay_tag_q [PD];

  // ---------------------------------------------------------------- CORDIC / range
  svf_pkg::svf_side_t cor_in, cor_out;
  logic [AW-1:0]      cor_acc;
  logic               rng_ok;

  always_comb begin
    cor_in.vld  = vld1_q;
    cor_in.zero = zero1_q;
  end

  svf_cordic #(
    .XW     (XW),
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (cor_in),
    .x_i    (cx1_q),
    .y_i    (cy1_q),
    .acc_i  (ca1_q),
    .side_o (cor_out),
    .acc_o  (cor_acc)
  );

  svf_range #(
    .CW  (CW),
    .LAT (CORDIC_STAGES)
  ) u_range (
    .clk_i   (clk_i),
    .en_i    (en),
    .mag_x_i (mx1_q),
    .mag_y_i (my1_q),
    .rad_i   (rad_c),
    .ok_o    (rng_ok)
  );

  // ---------------------------------------------------------------- F1..F3: bearing
  logic          f1_vld_q, f1_rok_q;
  logic [A-1:0]  f1_bear_q;
  logic          f2_vld_q, f2_rok_q;
  logic [A-1:0]  f2_d_q;
  logic          p_vld_q;   // last stage: kept cell

  logic [A-1:0]  bear_d;
  logic [A:0]    mag3;
  logic [A+1:0]  twice3;
  logic          full_view;
  logic          ang_ok;

  // a cell on the robot has bearing 0
  assign bear_d  = cor_out.zero ? '0 : A'((cor_acc + RND) >> (AW - A));

  // |d| of the wrapped difference; the half turn keeps magnitude 2^(A-1)
  assign mag3      = f2_d_q[A-1] ? ((A+1)'(1) << A) - {1'b0, f2_d_q} : {1'b0, f2_d_q};
  assign twice3    = {mag3, 1'b0};
  assign full_view = (VW'(view_q) >= (VW'(1) << A));
  assign ang_ok    = full_view | (VW'(twice3) <= VW'(view_q));

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q   <= 1'b0;
      vld1_q   <= 1'b0;
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      p_vld_q  <= 1'b0;
    end else if (en) begin
      vld0_q   <= cell_valid_i;
      vld1_q   <= vld0_q;
      f1_vld_q <= cor_out.vld;
      f2_vld_q <= f1_vld_q;
      p_vld_q  <= f2_vld_q & f2_rok_q & ang_ok;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx0_q <= DW'(cell_x_i) - DW'(pose_x_c);
      dy0_q <= DW'(cell_y_i) - DW'(pose_y_c);

      mx1_q   <= neg0 ? CW'(ndx0) : CW'(dx0_q);
      my1_q   <= dy0_q[DW-1] ? CW'(ndy0) : CW'(dy0_q);
      // left half plane: turn by a half turn first
      cx1_q   <= neg0 ? XW'(ndx0) : XW'(dx0_q);
      cy1_q   <= neg0 ? XW'(ndy0) : XW'(dy0_q);
      ca1_q   <= neg0 ? svf_pkg::HALF_TURN : '0;
      zero1_q <= (dx0_q == '0) && (dy0_q == '0);

      f1_bear_q <= bear_d;
      f1_rok_q  <= rng_ok;
      f2_d_q    <= f1_bear_q - heading_c;
      f2_rok_q  <= f1_rok_q;

      pay_x_q[0]   <= cell_x_i;
      pay_y_q[0]   <= cell_y_i;
      pay_tag_q[0] <= cell_tag_i;
      for (int k = 1; k < PD; k++) begin
        pay_x_q[k]   <= pay_x_q[k-1];
        pay_y_q[k]   <= pay_y_q[k-1];
        pay_tag_q[k] <= pay_tag_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- output + skid
  logic signed [CW-1:0]      out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic [svf_pkg::TAG_W-1:0] out_tag_q, skid_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (out_free) begin
      out_vld_q <= p_vld_q;
    end else begin
      skid_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_x_q   <= skid_x_q;
        out_y_q   <= skid_y_q;
        out_tag_q <= skid_tag_q;
      end
    end else if (out_free) begin
      out_x_q   <= pay_x_q[PD-1];
      out_y_q   <= pay_y_q[PD-1];
      out_tag_q <= pay_tag_q[PD-1];
    end else begin
      skid_x_q   <= pay_x_q[PD-1];
      skid_y_q   <= pay_y_q[PD-1];
      skid_tag_q <= pay_tag_q[PD-1];
    end
  end

  assign seen_valid_o = out_vld_q;
  assign seen_x_o     = out_x_q;
  assign seen_y_o     = out_y_q;
  assign seen_tag_o   = out_tag_q;

  // ---------------------------------------------------------------- checks
  `SVF_ASSERT_IMPLY(a_skid_behind_out, clk_i, rst_ni, skid_vld_q, out_vld_q)
  `SVF_ASSERT_IMPLY(a_skid_fill, clk_i, rst_ni, $rose(skid_vld_q), $past(out_vld_q && seen_stall_i))
  `SVF_ASSERT_IMPLY(a_skid_drain_to_out, clk_i, rst_ni, $fell(skid_vld_q), out_vld_q)
  `SVF_ASSERT_NEXT(a_kept_cell_shown, clk_i, rst_ni, !skid_vld_q && p_vld_q && out_free, out_vld_q)

endmodule

/* bench/sector_visibility_filter_test.sv */
// Self-checking bench for sector_visibility_filter: cell words in, visible cells out.
// Depends on svf_pkg and the RTL only; predicts each word from a bit-exact model.
`timescale 1ns / 1ps

module sector_visibility_filter_test;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned ANG_BITS = 16;
  localparam int unsigned STAGES   = 16;

  localparam int unsigned LATENCY      = STAGES + 6;
  localparam int unsigned SETTLE       = LATENCY + 10;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned CELLS_PER_SET = 80;

  // index that maps to no register; writes to it must be dropped
  localparam logic [svf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  localparam logic [31:0]   HALF_TURN_ACC = 32'h8000_0000;
  localparam logic [16:0]   FULL_VIEW     = 17'h10000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] tag;
  } cell_word_t;

  // per-step CORDIC angle, 2^32 per turn
  function automatic logic [31:0] arctan_step(int unsigned i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      default: return 32'h0000517D;
    endcase
  endfunction

  // Vectoring CORDIC atan2(y, x), left half plane folded by a half turn first.
  function automatic logic [ANG_BITS-1:0] bearing_of_offset(longint x, longint y);
    logic [31:0] acc;
    longint      xs;
    longint      ys;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      acc = HALF_TURN_ACC;
    end
    for (int unsigned i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + arctan_step(i);
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - arctan_step(i);
      end
    end
    // round half up to the output angle width
    acc = acc + (32'd1 << (31 - ANG_BITS));
    return acc[31 -: ANG_BITS];
  endfunction

  // Keeps its own copy of the registers and the queue of cells due on the output.
  class visibility_board;
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [15:0] heading;
    logic [31:0] range_lim;
    logic [16:0] view_w;
    cell_word_t  due_cells[$];
    int unsigned errors;

    function new();
      pose_x    = '0;
      pose_y    = '0;
      heading   = '0;
      range_lim = svf_pkg::RANGE_RST;
      view_w    = svf_pkg::VIEW_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [svf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        svf_pkg::CFG_POSE_X:      pose_x    = data;
        svf_pkg::CFG_POSE_Y:      pose_y    = data;
        svf_pkg::CFG_HEADING:     heading   = data[15:0];
        svf_pkg::CFG_RANGE_LIMIT: range_lim = data;
        svf_pkg::CFG_VIEW_WIDTH:  view_w    = data[16:0];
        default: ;
      endcase
    endfunction

    function bit in_view(logic [31:0] x, logic [31:0] y);
      longint      dx;
      longint      dy;
      logic [32:0] ax;
      logic [32:0] ay;
      logic [65:0] dist2;
      logic [65:0] reach2;
      logic [15:0] diff;
      logic [16:0] mag;
      dx = longint'($signed(x)) - longint'($signed(pose_x));
      dy = longint'($signed(y)) - longint'($signed(pose_y));
      ax = 33'(dx < 0 ? -dx : dx);
      ay = 33'(dy < 0 ? -dy : dy);
      dist2  = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      reach2 = 66'(range_lim) * 66'(range_lim);
      if (dist2 > reach2) return 1'b0;
      if (view_w >= FULL_VIEW) return 1'b1;
      diff = bearing_of_offset(dx, dy) - heading;
      // half-turn difference counts as magnitude 2^15
      mag  = diff[15] ? FULL_VIEW - {1'b0, diff} : {1'b0, diff};
      return {mag, 1'b0} <= {1'b0, view_w};
    endfunction

    function void note_cell(logic [31:0] x, logic [31:0] y, logic [31:0] tag);
      cell_word_t kept;
      if (in_view(x, y)) begin
        kept = '{x: x, y: y, tag: tag};
        due_cells.insert(due_cells.size(), kept);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_seen(logic [31:0] x, logic [31:0] y, logic [31:0] tag);
      cell_word_t want;
      if (due_cells.size() == 0) begin
        report("unexpected word, x", x, 32'h0);
        return;
      end
      want = due_cells.pop_front();
      if (x !== want.x) report("seen_x", x, want.x);
      if (y !== want.y) report("seen_y", y, want.y);
      if (tag !== want.tag) report("seen_tag", tag, want.tag);
    endtask

    function int unsigned pending();
      return due_cells.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              cfg_we_i   = 1'b0;
  logic [svf_pkg::CFG_IDX_W-1:0]     cfg_idx_i  = '0;
  logic [svf_pkg::CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                              cell_valid_i = 1'b0;
  logic                              cell_stall_o;
  logic signed [COORD_W-1:0]         cell_x_i   = '0;
  logic signed [COORD_W-1:0]         cell_y_i   = '0;
  logic [svf_pkg::TAG_W-1:0]         cell_tag_i = '0;
  logic                              seen_valid_o;
  logic                              seen_stall_i = 1'b0;
  logic signed [COORD_W-1:0]         seen_x_o;
  logic signed [COORD_W-1:0]         seen_y_o;
  logic [svf_pkg::TAG_W-1:0]         seen_tag_o;

  // idle percentages of the current phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;

  visibility_board board;

  sector_visibility_filter #(
    .COORD_WIDTH   (COORD_W),
    .ANGLE_BITS    (ANG_BITS),
    .CORDIC_STAGES (STAGES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cell_valid_i (cell_valid_i),
    .cell_stall_o (cell_stall_o),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_tag_i   (cell_tag_i),
    .seen_valid_o (seen_valid_o),
    .seen_stall_i (seen_stall_i),
    .seen_x_o     (seen_x_o),
    .seen_y_o     (seen_y_o),
    .seen_tag_o   (seen_tag_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("FAILURE");
    $finish;
  end

  // Output side: take a word at any edge with valid high and stall low, then pick the
  // stall for the next cycle. Outputs are read at the edge, before the RTL updates land.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      seen_stall_i <= 1'b0;
    end else begin
      if (seen_valid_o && !seen_stall_i) board.check_seen(seen_x_o, seen_y_o, seen_tag_o);
      seen_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // One cell word. Random idle cycles go ahead of it; once raised, valid and the
  // payload hold until the edge that takes the word.
  task send_cell(logic [31:0] x, logic [31:0] y, logic [31:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cell_valid_i <= 1'b1;
    cell_x_i     <= x;
    cell_y_i     <= y;
    cell_tag_i   <= tag;
    @(posedge clk_i);
    while (cell_stall_o) @(posedge clk_i);
    board.note_cell(x, y, tag);
  endtask

  // Wait for every kept cell, then let any dropped ones flush out of the pipe.
  task drain();
    cell_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all five registers plus one dead index; only called with the block idle.
  task load_view(logic [31:0] px, logic [31:0] py, logic [15:0] hd, logic [31:0] rl,
                 logic [16:0] vw);
    logic [svf_pkg::CFG_IDX_W-1:0] idx  [6];
    logic [31:0]                   data [6];
    idx  = '{svf_pkg::CFG_POSE_X, svf_pkg::CFG_POSE_Y, CFG_SPARE, svf_pkg::CFG_HEADING,
             svf_pkg::CFG_RANGE_LIMIT, svf_pkg::CFG_VIEW_WIDTH};
    data = '{px, py, $urandom, {16'h0, hd}, rl, {15'h0, vw}};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= data[i];
      @(posedge clk_i);
      board.write_reg(idx[i], data[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random cells: some anywhere, some right on or just past the range along an axis,
  // most scattered around the robot at a scale set by the current range.
  task run_cells(int unsigned count);
    int unsigned pick;
    longint      reach;
    longint      span;
    longint      ox;
    longint      oy;
    longint      swap;
    bit [63:0]   rnd;
    logic [31:0] cx;
    logic [31:0] cy;
    for (int unsigned n = 0; n < count; n++) begin
      pick  = $urandom_range(99);
      reach = longint'(board.range_lim);
      if (pick < 15) begin
        cx = $urandom;
        cy = $urandom;
      end else begin
        if (pick < 30) begin
          ox = $urandom_range(1) ? reach : reach + 1;
          if ($urandom_range(1)) ox = -ox;
          oy = 0;
          if ($urandom_range(1)) begin
            swap = ox;
            ox   = oy;
            oy   = swap;
          end
        end else begin
          span = (pick < 65) ? reach : 2 * reach;
          rnd  = {$urandom, $urandom};
          ox   = longint'(rnd % (2 * span + 1)) - span;
          rnd  = {$urandom, $urandom};
          oy   = longint'(rnd % (2 * span + 1)) - span;
        end
        cx = board.pose_x + ox[31:0];
        cy = board.pose_y + oy[31:0];
      end
      send_cell(cx, cy, $urandom);
    end
  endtask

  initial begin
    logic [31:0] rl;
    logic [16:0] vw;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset view: full circle, one metre radius
    send_cell(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);  // on the robot
    send_cell(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);  // exactly on the rim
    send_cell(32'h0001_0001, 32'h0000_0000, 32'h1234_5678);  // one lsb past
    send_cell(32'h0000_0000, 32'hFFFF_0000, 32'hA5A5_A5A5);
    send_cell(32'd46340, 32'd46340, 32'h5A5A_5A5A);          // diagonal, inside
    send_cell(32'd46341, 32'd46341, 32'h0F0F_0F0F);          // diagonal, outside
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hF0F0_F0F0);
    send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_cell(32'hFFFF_FFFF, 32'h0000_0001, 32'hDEAD_BEEF);
    send_cell(32'h0000_0001, 32'hFFFF_FFFF, 32'hC001_D00D);
    send_cell(32'hFFFF_0000, 32'h0000_0000, 32'h0000_FFFF);
    drain();

    // near-full view facing +x: the cell straight behind sits exactly a half turn off
    load_view(32'h0, 32'h0, 16'h0000, 32'hFFFF_FFFF, 17'd65535);
    send_cell(32'h0000_0000, 32'h0000_0000, 32'h1111_1111);
    send_cell(32'hFFFF_0000, 32'h0000_0000, 32'h2222_2222);
    send_cell(32'h0001_0000, 32'h0000_0000, 32'h3333_3333);
    send_cell(32'h0000_0000, 32'h0001_0000, 32'h4444_4444);
    send_cell(32'h0000_0000, 32'hFFFF_0000, 32'h5555_5555);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h6666_6666);
    send_cell(32'h0000_0001, 32'hFFFF_FFFF, 32'h7777_7777);
    send_cell(32'hFFFF_0000, 32'h0000_0001, 32'h8888_8888);
    send_cell(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h9999_9999);
    drain();

    // random phases; idling style rotates with the phase number
    for (int unsigned s = 0; s < 9; s++) begin
      case (s % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      case (s)
        0: load_view(32'h0, 32'h0, 16'h0000, 32'd1, 17'd1);
        1: load_view(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF, 17'd65535);
        2: load_view(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 32'd65536, FULL_VIEW);
        3: load_view($urandom, $urandom, 16'h4000, 32'h000A_0000, 17'd32768);
        default: begin
          case ($urandom_range(2))
            0: rl = $urandom_range(1, 1000);
            1: rl = $urandom_range(1, 32'h00FF_FFFF);
            default: rl = $urandom;
          endcase
          if (rl == 0) rl = 1;
          vw = ($urandom_range(3) == 0) ? FULL_VIEW : 17'($urandom_range(1, 65536));
          load_view($urandom, $urandom, 16'($urandom_range(65535)), rl, vw);
        end
      endcase
      run_cells(CELLS_PER_SET);
      drain();
    end

    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
